@@ rtl/core/i2cm_pkg.sv @@
// shared types, request codes and phase tables for the i2c master bit engine
package i2cm_pkg;

  // bits shifted per byte operation
  localparam int BITS_PER_BYTE = 8;

  // msb select for the transmit shifter
  localparam logic [7:0] MSB_MASK = 8'h80;

  // request codes on in_req_type
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;
  localparam logic [2:0] REQ_SACK  = 3'd5;
  localparam logic [2:0] REQ_RACK  = 3'd6;

  // operation in progress, idle when none
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_t;

  // item class decided by the front end
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_NOP  = 2'd2
  } kind_t;

  // classified item passed from front to back
  typedef struct packed {
    kind_t      kind;
    op_t        op;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  // handshake from the front queue to the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } item_chan_t;

  // one result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_ack;
    logic       rejected;
  } result_t;

  // number of pin phases for each operation
  function automatic logic [4:0] phase_total(op_t op);
    logic [4:0] total;
    unique case (op)
      OP_START: total = 5'd4;
      OP_STOP:  total = 5'd3;
      OP_WRITE: total = 5'(3 * BITS_PER_BYTE);
      OP_READ:  total = 5'(1 + 2 * BITS_PER_BYTE);
      OP_SACK:  total = 5'd3;
      OP_RACK:  total = 5'd3;
      default:  total = 5'd0;
    endcase
    return total;
  endfunction

endpackage

@@ rtl/core/i2c_master_bit_engine.sv @@
// top level of the i2c master pin sequencer
//
// Both channels behave as queues. Push an item with push while full is
// low: a tick (req type 0) advances one SCL/SDA phase of the running
// operation, codes 1..6 start start, stop, write byte, read byte, send ack
// or receive ack. Each accepted item yields exactly one result item, read
// from the out_ ports while empty is low and taken with pop.
// A tick's sda_in is the line level seen in the phase it ends; it is
// sampled on the phases that drive SCL low in read byte and receive ack.
// A command issued while an operation runs is dropped and flagged rejected.
// Throughput is one item per clock while the result queue has room; the
// back end holds while it is full and nothing is popped. An accepted item
// passes through the two-entry input queue, then the two-entry result queue.
// When the receiver stops popping, the result queue fills, the back end
// holds, and full rises once the input queue has two items waiting.
// Reset clears both queues and returns SCL and SDA to released, idle.
module i2c_master_bit_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_data_byte,
  input  logic       in_ack_level,
  input  logic       in_sda_in,
  output logic       empty,
  input  logic       pop,
  output logic       out_scl_level,
  output logic       out_sda_drive,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_ack,
  output logic       out_rejected
);
  import i2cm_pkg::*;

  item_chan_t q_head;
  logic       q_pop;
  result_t    res_head;

  // classify and queue incoming items
  i2cm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .in_ack_level (in_ack_level),
    .in_sda_in    (in_sda_in),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  // pin sequencer and result queue
  i2cm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .res_head (res_head)
  );

  // result fields
  assign out_scl_level = res_head.scl_level;
  assign out_sda_drive = res_head.sda_drive;
  assign out_busy_res  = res_head.busy_res;
  assign out_done_res  = res_head.done_res;
  assign out_rx_byte   = res_head.rx_byte;
  assign out_rx_ack    = res_head.rx_ack;
  assign out_rejected  = res_head.rejected;

endmodule

@@ rtl/core/i2cm_front.sv @@
// front end: classifies incoming items and holds them in a two-entry queue
module i2cm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          in_req_type,
  input  logic [7:0]          in_data_byte,
  input  logic                in_ack_level,
  input  logic                in_sda_in,
  output i2cm_pkg::item_chan_t q_head,
  input  logic                q_pop
);
  import i2cm_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  item_t      cls;
  logic       do_push;
  logic       do_pop;

  // decode the request code into an item class
  always_comb begin
    cls.op        = OP_IDLE;
    cls.data_byte = in_data_byte;
    cls.ack_level = in_ack_level;
    cls.sda_in    = in_sda_in;
    unique case (in_req_type) inside
      REQ_TICK: begin
        cls.kind = KIND_TICK;
      end
      REQ_START, REQ_STOP, REQ_WRITE, REQ_READ, REQ_SACK, REQ_RACK: begin
        cls.kind = KIND_CMD;
        cls.op   = op_t'(in_req_type);
      end
      default: begin
        cls.kind = KIND_NOP;
      end
    endcase
  end

  // queue pointers and fill count
  assign full     = (count_r == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = q_pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  assign q_head.valid = (count_r != 2'd0);
  assign q_head.item  = mem_r[rd_ptr_r];

endmodule

@@ rtl/core/i2cm_back.sv @@
// back end: runs the pin sequencer and queues one result per item
module i2cm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cm_pkg::item_chan_t q_head,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output i2cm_pkg::result_t    res_head
);
  import i2cm_pkg::*;

  op_t        op_r, op_nxt;
  logic [4:0] phase_r, phase_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] rx_byte_r, rx_byte_nxt;
  logic       rx_ack_r, rx_ack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_hold_r, ack_hold_nxt;
  logic       done;
  logic       rej;
  logic       take;
  logic       res_pop;
  result_t    res;

  result_t    res_mem_r [2];
  logic       res_wr_r, res_rd_r;
  logic [1:0] res_cnt_r, res_cnt_nxt;

  item_t      it;

  // take an item when the result queue has room
  assign it      = q_head.item;
  assign res_pop = pop && (res_cnt_r != 2'd0);
  assign take    = q_head.valid && ((res_cnt_r != 2'd2) || res_pop);
  assign q_pop   = take;

  // one phase of the current operation, or a command load
  always_comb begin
    op_nxt       = op_r;
    phase_nxt    = phase_r;
    sub_nxt      = sub_r;
    shift_nxt    = shift_r;
    rx_byte_nxt  = rx_byte_r;
    rx_ack_nxt   = rx_ack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    ack_hold_nxt = ack_hold_r;
    done         = 1'b0;
    rej          = 1'b0;
    if (take) begin
      case (it.kind)
        KIND_TICK: begin
          if (op_r != OP_IDLE) begin
            unique case (op_r)
              OP_START: begin
                case (phase_r)
                  5'd0:    sda_nxt = 1'b1;
                  5'd1:    scl_nxt = 1'b1;
                  5'd2:    sda_nxt = 1'b0;
                  default: scl_nxt = 1'b0;
                endcase
              end
              OP_STOP: begin
                case (phase_r)
                  5'd0:    sda_nxt = 1'b0;
                  5'd1:    scl_nxt = 1'b1;
                  default: sda_nxt = 1'b1;
                endcase
              end
              OP_WRITE: begin
                sub_nxt = (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
                case (sub_r)
                  2'd0:    sda_nxt = |(shift_r & MSB_MASK);
                  2'd1:    scl_nxt = 1'b1;
                  default: begin
                    scl_nxt   = 1'b0;
                    shift_nxt = {shift_r[6:0], 1'b0};
                  end
                endcase
              end
              OP_READ: begin
                if (phase_r == 5'd0) begin
                  sda_nxt = 1'b1;
                end else if (phase_r[0]) begin
                  scl_nxt = 1'b1;
                end else begin
                  scl_nxt   = 1'b0;
                  shift_nxt = {shift_r[6:0], it.sda_in};
                end
              end
              OP_SACK: begin
                case (phase_r)
                  5'd0:    sda_nxt = ack_hold_r;
                  5'd1:    scl_nxt = 1'b1;
                  default: scl_nxt = 1'b0;
                endcase
              end
              OP_RACK: begin
                case (phase_r)
                  5'd0:    sda_nxt = 1'b1;
                  5'd1:    scl_nxt = 1'b1;
                  default: begin
                    scl_nxt    = 1'b0;
                    rx_ack_nxt = it.sda_in;
                  end
                endcase
              end
              default: ;
            endcase
            // advance and check for the last phase
            phase_nxt = phase_r + 5'd1;
            if (phase_nxt >= phase_total(op_r)) begin
              if (op_r == OP_READ) begin
                rx_byte_nxt = shift_nxt;
              end
              op_nxt    = OP_IDLE;
              phase_nxt = 5'd0;
              done      = 1'b1;
            end
          end
        end
        KIND_CMD: begin
          if (op_r != OP_IDLE) begin
            rej = 1'b1;
          end else begin
            op_nxt    = it.op;
            phase_nxt = 5'd0;
            sub_nxt   = 2'd0;
            case (it.op)
              OP_WRITE: shift_nxt    = it.data_byte;
              OP_READ:  shift_nxt    = 8'd0;
              OP_SACK:  ack_hold_nxt = it.ack_level;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r       <= OP_IDLE;
      phase_r    <= 5'd0;
      sub_r      <= 2'd0;
      shift_r    <= 8'd0;
      rx_byte_r  <= 8'd0;
      rx_ack_r   <= 1'b1;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      ack_hold_r <= 1'b0;
    end else begin
      op_r       <= op_nxt;
      phase_r    <= phase_nxt;
      sub_r      <= sub_nxt;
      shift_r    <= shift_nxt;
      rx_byte_r  <= rx_byte_nxt;
      rx_ack_r   <= rx_ack_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      ack_hold_r <= ack_hold_nxt;
    end
  end

  // result item after this step
  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_drive = sda_nxt;
    res.busy_res  = (op_nxt != OP_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_byte_nxt;
    res.rx_ack    = rx_ack_nxt;
    res.rejected  = rej;
  end

  // result queue control
  assign res_cnt_nxt = res_cnt_r + {1'b0, take} - {1'b0, res_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      res_wr_r  <= take ? ~res_wr_r : res_wr_r;
      res_rd_r  <= res_pop ? ~res_rd_r : res_rd_r;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (take) begin
      res_mem_r[res_wr_r] <= res;
    end
  end

  assign empty    = (res_cnt_r == 2'd0);
  assign res_head = res_mem_r[res_rd_r];

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the i2c master bit engine
`timescale 1ns / 1ps

import i2cm_pkg::*;

// tracks pin and status state and checks each result item in order
class pin_scoreboard;
  op_t        op;
  logic [4:0] phase;
  logic [7:0] shifter;
  logic [7:0] rx_byte;
  logic       rx_ack;
  logic       scl;
  logic       sda;
  logic       ack_hold;
  result_t    pending_pins[$];
  int         fail_count;

  function new();
    op         = OP_IDLE;
    phase      = '0;
    shifter    = '0;
    rx_byte    = '0;
    rx_ack     = 1'b1;
    scl        = 1'b1;
    sda        = 1'b1;
    ack_hold   = 1'b0;
    fail_count = 0;
  endfunction

  // pin phases that each operation takes
  static function int phase_len(logic [2:0] code);
    case (code)
      REQ_START: return 4;
      REQ_STOP:  return 3;
      REQ_WRITE: return 3 * BITS_PER_BYTE;
      REQ_READ:  return 1 + 2 * BITS_PER_BYTE;
      REQ_SACK:  return 3;
      REQ_RACK:  return 3;
      default:   return 0;
    endcase
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // advance the state by one accepted item and queue the pins it leaves
  function void note_item(logic [2:0] req, logic [7:0] data, logic ack, logic sda_in);
    result_t r;
    logic    done;
    logic    rej;
    done = 1'b0;
    rej  = 1'b0;
    if (req == REQ_TICK) begin
      if (op != OP_IDLE) begin
        // one pin write of the running operation
        case (op)
          OP_START: begin
            if (phase == 0) sda = 1'b1;
            else if (phase == 1) scl = 1'b1;
            else if (phase == 2) sda = 1'b0;
            else scl = 1'b0;
          end
          OP_STOP: begin
            if (phase == 0) sda = 1'b0;
            else if (phase == 1) scl = 1'b1;
            else sda = 1'b1;
          end
          OP_WRITE: begin
            if (phase % 3 == 0) begin
              sda = shifter[7];
            end else if (phase % 3 == 1) begin
              scl = 1'b1;
            end else begin
              scl = 1'b0;
              shifter = {shifter[6:0], 1'b0};
            end
          end
          OP_READ: begin
            if (phase == 0) begin
              sda = 1'b1;
            end else if (phase[0]) begin
              scl = 1'b1;
            end else begin
              scl = 1'b0;
              shifter = {shifter[6:0], sda_in};
            end
          end
          OP_SACK: begin
            if (phase == 0) sda = ack_hold;
            else if (phase == 1) scl = 1'b1;
            else scl = 1'b0;
          end
          OP_RACK: begin
            if (phase == 0) begin
              sda = 1'b1;
            end else if (phase == 1) begin
              scl = 1'b1;
            end else begin
              scl = 1'b0;
              rx_ack = sda_in;
            end
          end
          default: ;
        endcase
        phase = phase + 5'd1;
        if (int'(phase) >= phase_len(op)) begin
          if (op == OP_READ) rx_byte = shifter;
          op    = OP_IDLE;
          phase = '0;
          done  = 1'b1;
        end
      end
    end else if (req <= REQ_RACK) begin
      if (op != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        // load a new operation, pins move on later ticks
        op    = op_t'(req);
        phase = '0;
        if (req == REQ_WRITE) shifter = data;
        else if (req == REQ_READ) shifter = '0;
        else if (req == REQ_SACK) ack_hold = ack;
      end
    end
    r.scl_level = scl;
    r.sda_drive = sda;
    r.busy_res  = (op != OP_IDLE);
    r.done_res  = done;
    r.rx_byte   = rx_byte;
    r.rx_ack    = rx_ack;
    r.rejected  = rej;
    pending_pins.push_back(r);
  endfunction

  task compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // compare one popped result with the oldest expectation
  task check_pins(result_t got);
    result_t want;
    if (pending_pins.size() == 0) begin
      report_mismatch("result item with nothing expected");
    end else begin
      want = pending_pins.pop_front();
      compare_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
      compare_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
      compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
      compare_field("rx_byte", got.rx_byte, want.rx_byte);
      compare_field("rx_ack", 8'(got.rx_ack), 8'(want.rx_ack));
      compare_field("rejected", 8'(got.rejected), 8'(want.rejected));
    end
  endtask
endclass

module tb_top;
  localparam logic [2:0] REQ_NONE = 3'd7;
  localparam int         ITEM_TARGET = 1900;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [2:0] in_req_type = REQ_TICK;
  logic [7:0] in_data_byte = '0;
  logic       in_ack_level = 1'b0;
  logic       in_sda_in = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_scl_level;
  logic       out_sda_drive;
  logic       out_busy_res;
  logic       out_done_res;
  logic [7:0] out_rx_byte;
  logic       out_rx_ack;
  logic       out_rejected;

  pin_scoreboard sb = new();
  bit            calm = 1'b0;
  bit            started = 1'b0;
  int            item_count = 0;

  i2c_master_bit_engine u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_req_type   (in_req_type),
    .in_data_byte  (in_data_byte),
    .in_ack_level  (in_ack_level),
    .in_sda_in     (in_sda_in),
    .empty         (empty),
    .pop           (pop),
    .out_scl_level (out_scl_level),
    .out_sda_drive (out_sda_drive),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rx_byte   (out_rx_byte),
    .out_rx_ack    (out_rx_ack),
    .out_rejected  (out_rejected)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // push one item, holding it until the block takes it
  task automatic send_item(logic [2:0] req, logic [7:0] data, logic ack, logic sda_in);
    while (!calm && $urandom_range(99) < 13) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_req_type  <= req;
    in_data_byte <= data;
    in_ack_level <= ack;
    in_sda_in    <= sda_in;
    do @(posedge clk); while (full);
    sb.note_item(req, data, ack, sda_in);
  endtask

  // hold off the sender until every result item has come back
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_pins.size() != 0) @(posedge clk);
  endtask

  // tick with random side fields and a chosen sda level
  task automatic send_tick(logic sda_in);
    send_item(REQ_TICK, 8'($urandom), 1'($urandom), sda_in);
  endtask

  // one command with all its ticks, sometimes with noise while it runs
  task automatic run_operation();
    logic [2:0] code;
    logic [7:0] data;
    int         len;
    int         sda_mode;
    int         pick;
    code     = 3'($urandom_range(REQ_START, REQ_RACK));
    pick     = $urandom_range(9);
    data     = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
    sda_mode = $urandom_range(5);
    len      = sb.phase_len(code);
    send_item(code, data, 1'($urandom), 1'($urandom));
    for (int i = 0; i < len; i++) begin
      // a command while busy is dropped, code seven is ignored
      if ($urandom_range(99) < 6)
        send_item(3'($urandom_range(REQ_START, REQ_NONE)), 8'($urandom),
                  1'($urandom), 1'($urandom));
      if (sda_mode == 0) send_tick(1'b0);
      else if (sda_mode == 1) send_tick(1'b1);
      else send_tick(1'($urandom));
    end
    item_count += 1 + len;
  endtask

  // result side: pop at random and check what comes out
  initial begin
    result_t got;
    wait (started);
    forever begin
      if (pop && !empty) begin
        got.scl_level = out_scl_level;
        got.sda_drive = out_sda_drive;
        got.busy_res  = out_busy_res;
        got.done_res  = out_done_res;
        got.rx_byte   = out_rx_byte;
        got.rx_ack    = out_rx_ack;
        got.rejected  = out_rejected;
        sb.check_pins(got);
      end
      pop <= calm || ($urandom_range(99) >= 13);
      @(posedge clk);
    end
  end

  // stimulus and end of run
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    started = 1'b1;

    // directed: an idle tick, code seven, start, receive ack, send ack, stop, busy rejection
    send_item(REQ_TICK, 8'hFF, 1'b1, 1'b1);
    send_item(REQ_NONE, 8'h00, 1'b0, 1'b0);
    send_item(REQ_START, 8'h00, 1'b0, 1'b0);
    repeat (4) send_tick(1'b1);
    send_item(REQ_RACK, 8'h00, 1'b0, 1'b0);
    send_tick(1'b1);
    send_item(REQ_WRITE, 8'hFF, 1'b1, 1'b1);
    send_item(REQ_NONE, 8'hFF, 1'b1, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_item(REQ_SACK, 8'h00, 1'b1, 1'b0);
    repeat (3) send_tick(1'b0);
    send_item(REQ_STOP, 8'h00, 1'b0, 1'b0);
    repeat (3) send_tick(1'b0);
    drain();

    // random: mostly complete operations, some idle noise between them
    while (item_count < ITEM_TARGET) begin
      if ($urandom_range(99) < 10) begin
        if ($urandom_range(1)) send_tick(1'($urandom));
        else send_item(REQ_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      end
      run_operation();
      calm = (item_count > 700 && item_count < 1100);
      if (item_count > 1200 && item_count < 1240) drain();
    end
    calm = 1'b1;
    drain();
    repeat (10) @(posedge clk);

    if (sb.pending_pins.size() != 0)
      sb.report_mismatch("expected result items never arrived");
    if (sb.fail_count == 0)
      $display("i2c_master_bit_engine test passed");
    else
      $display("i2c_master_bit_engine test failed");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #20_000_000;
    $display("i2c_master_bit_engine test failed");
    $finish;
  end
endmodule

@@ i2c_master_bit_engine.f @@
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_back.sv
rtl/core/i2c_master_bit_engine.sv
tb/tb_top.sv
